// ----- rtl/chained_hash_map_top_macros.svh -----
// assertion macros for the chained hash map
`ifndef CHAINED_HASH_MAP_TOP_MACROS_SVH
`define CHAINED_HASH_MAP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CHM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("chm check failed");
`define CHM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("chm check failed");
`else
`define CHM_ASSERT_SAME(lbl, ante, cons)
`define CHM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/chm_pkg.sv -----
// shared constants, types and command structs of the chained hash map
`timescale 1ns / 1ps
package chm_pkg;
    localparam int BUCKETS      = 64;
    localparam int POOL_ENTRIES = 256;
    localparam int BUCKET_W     = $clog2(BUCKETS);
    localparam int IDX_W        = $clog2(POOL_ENTRIES);
    localparam int LINK_W       = IDX_W + 1;
    localparam int CFG_W        = 7;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;
    localparam int ITEM_W       = 9;
    localparam int GROUP        = 8;
    localparam int GROUPS       = POOL_ENTRIES / GROUP;
    localparam int GRP_W        = $clog2(GROUPS);
    localparam int SEL_W        = $clog2(GROUP);
    localparam int MCNT_W       = $clog2(KEY_W + 1);

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_ENTRIES);

    typedef enum logic [1:0] {MODE_ADD, MODE_DEL, MODE_GET, MODE_NOP} t_mode;
    typedef enum logic [1:0] {ST_OK, ST_DUP, ST_NOTFOUND, ST_FULL} t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_CALC, S_HEAD, S_PROBE, S_NODEW, S_TAIL, S_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]       mode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [VAL_W-1:0]  found_value;
        logic [ITEM_W-1:0] item_total;
    } t_rsp;

    typedef struct packed {
        logic    load;
        logic    start;
        logic    head_rd;
        logic    take_head;
        logic    step;
        logic    wr_node;
        logic    wr_tail;
        logic    unlink;
        logic    take_value;
        logic    rsp_load;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic  calc_done;
        logic  cur_nil;
        logic  key_hit;
        logic  full;
        logic  out_free;
        t_mode mode;
    } t_sts;
endpackage

// ----- rtl/chm_req_if.sv -----
// request channel interface
`timescale 1ns / 1ps
interface chm_req_if;
    logic          valid;
    logic          ready;
    chm_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/chm_rsp_if.sv -----
// result channel interface
`timescale 1ns / 1ps
interface chm_rsp_if;
    logic          valid;
    logic          ready;
    chm_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/chm_ram.sv -----
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/chm_ctrl.sv -----
// request sequencer state machine
`timescale 1ns / 1ps
module chm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  chm_pkg::t_sts i_sts,
    output chm_pkg::t_cmd o_cmd
);
    import chm_pkg::*;

    t_state  r_state, n_state;
    t_status r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        o_cmd       = '0;
        o_cmd.status = r_status;
        o_req_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.mode == MODE_NOP) begin
                    n_status = ST_OK;
                    n_state  = S_RESP;
                end else if (i_sts.mode == MODE_ADD && i_sts.full) begin
                    n_status = ST_FULL;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_CALC;
                end
            end
            S_CALC: begin
                if (i_sts.calc_done) begin
                    o_cmd.head_rd = 1'b1;
                    n_state       = S_HEAD;
                end
            end
            S_HEAD: begin
                o_cmd.take_head = 1'b1;
                n_state         = S_PROBE;
            end
            S_PROBE: begin
                if (!i_sts.cur_nil) begin
                    n_state = S_NODEW;
                end else if (i_sts.mode == MODE_ADD) begin
                    o_cmd.wr_node = 1'b1;
                    n_state       = S_TAIL;
                end else begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_RESP;
                end
            end
            S_NODEW: begin
                if (!i_sts.key_hit) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_PROBE;
                end else begin
                    n_state = S_RESP;
                    unique case (i_sts.mode)
                        MODE_ADD: n_status = ST_DUP;
                        MODE_DEL: begin
                            o_cmd.unlink = 1'b1;
                            n_status     = ST_OK;
                        end
                        default: begin
                            o_cmd.take_value = 1'b1;
                            n_status         = ST_OK;
                        end
                    endcase
                end
            end
            S_TAIL: begin
                o_cmd.wr_tail = 1'b1;
                n_status      = ST_OK;
                n_state       = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.rsp_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ----- rtl/chm_dp.sv -----
// datapath: modulo unit, free node scan, bucket and node stores, result register
`timescale 1ns / 1ps
module chm_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [chm_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  chm_pkg::t_req              i_req,
    input  chm_pkg::t_cmd              i_cmd,
    output chm_pkg::t_sts              o_sts,
    output logic                       o_rsp_valid,
    input  logic                       i_rsp_ready,
    output chm_pkg::t_rsp              o_rsp
);
    import chm_pkg::*;

    logic [CFG_W-1:0]        r_bc;
    t_req                    r_req;
    logic [BUCKET_W-1:0]     r_rem;
    logic [KEY_W-1:0]        r_mkey;
    logic [MCNT_W-1:0]       r_mcnt;
    logic [GRP_W-1:0]        r_grp;
    logic                    r_scan_on;
    logic [IDX_W-1:0]        r_free_idx;
    logic [POOL_ENTRIES-1:0] r_in_use;
    logic [BUCKETS-1:0]      r_head_vld;
    logic                    r_head_vld_q;
    logic [LINK_W-1:0]       r_cur;
    logic [LINK_W-1:0]       r_prev;
    logic [VAL_W-1:0]        r_found;
    logic [ITEM_W-1:0]       r_count;
    logic                    r_out_valid;
    t_rsp                    r_out;

    logic [CFG_W-1:0]    w_bc_clip;
    logic [BUCKET_W:0]   w_div;
    logic [BUCKET_W:0]   w_trial;
    logic [GROUP-1:0]    w_grp_bits;
    logic [SEL_W-1:0]    w_sel;
    logic                w_any;
    logic                w_prev_nil;
    logic [LINK_W-1:0]   w_head_rdata;
    logic [KEY_W-1:0]    w_key_rdata;
    logic [VAL_W-1:0]    w_val_rdata;
    logic [LINK_W-1:0]   w_link_rdata;
    logic                w_head_we;
    logic [LINK_W-1:0]   w_head_wdata;
    logic                w_link_we;
    logic [IDX_W-1:0]    w_link_waddr;
    logic [LINK_W-1:0]   w_link_wdata;

    // effective bucket count and one restoring step
    always_comb begin
        if (r_bc == '0) begin
            w_bc_clip = CFG_W'(1);
        end else if (r_bc > CFG_W'(BUCKETS)) begin
            w_bc_clip = CFG_W'(BUCKETS);
        end else begin
            w_bc_clip = r_bc;
        end
        w_div   = (BUCKET_W+1)'(w_bc_clip);
        w_trial = {r_rem, r_mkey[KEY_W-1]};
    end

    // lowest free node within the current group
    always_comb begin
        w_grp_bits = r_in_use[{r_grp, SEL_W'(0)} +: GROUP];
        w_sel      = '0;
        w_any      = 1'b0;
        for (int i = GROUP - 1; i >= 0; i--) begin
            if (!w_grp_bits[i]) begin
                w_sel = SEL_W'(i);
                w_any = 1'b1;
            end
        end
    end

    assign w_prev_nil = (r_prev == NIL_LINK);

    assign w_head_we    = (i_cmd.wr_tail || i_cmd.unlink) && w_prev_nil;
    assign w_head_wdata = i_cmd.wr_tail ? {1'b0, r_free_idx} : w_link_rdata;
    assign w_link_we    = i_cmd.wr_node || ((i_cmd.wr_tail || i_cmd.unlink) && !w_prev_nil);
    assign w_link_waddr = i_cmd.wr_node ? r_free_idx : r_prev[IDX_W-1:0];
    assign w_link_wdata = i_cmd.wr_node ? NIL_LINK :
                          i_cmd.wr_tail ? {1'b0, r_free_idx} : w_link_rdata;

    chm_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_head (
        .i_clk   (i_clk),
        .i_we    (w_head_we),
        .i_waddr (r_rem),
        .i_wdata (w_head_wdata),
        .i_raddr (r_rem),
        .o_rdata (w_head_rdata)
    );

    chm_ram #(.WIDTH(KEY_W), .DEPTH(POOL_ENTRIES)) u_key (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_node),
        .i_waddr (r_free_idx),
        .i_wdata (r_req.key),
        .i_raddr (r_cur[IDX_W-1:0]),
        .o_rdata (w_key_rdata)
    );

    chm_ram #(.WIDTH(VAL_W), .DEPTH(POOL_ENTRIES)) u_val (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_node),
        .i_waddr (r_free_idx),
        .i_wdata (r_req.value),
        .i_raddr (r_cur[IDX_W-1:0]),
        .o_rdata (w_val_rdata)
    );

    chm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_ENTRIES)) u_link (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (w_link_waddr),
        .i_wdata (w_link_wdata),
        .i_raddr (r_cur[IDX_W-1:0]),
        .o_rdata (w_link_rdata)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.start) begin
            r_rem  <= '0;
            r_mkey <= r_req.key;
        end else if (r_mcnt != '0) begin
            r_mkey <= {r_mkey[KEY_W-2:0], 1'b0};
            if (w_trial >= w_div) begin
                r_rem <= BUCKET_W'(w_trial - w_div);
            end else begin
                r_rem <= BUCKET_W'(w_trial);
            end
        end
        if (i_cmd.start) begin
            r_grp <= '0;
        end else if (r_scan_on && !w_any) begin
            r_grp <= r_grp + GRP_W'(1);
        end
        if (r_scan_on && w_any) begin
            r_free_idx <= {r_grp, w_sel};
        end
        if (i_cmd.head_rd) begin
            r_head_vld_q <= r_head_vld[r_rem];
        end
        if (i_cmd.take_head) begin
            r_cur  <= r_head_vld_q ? w_head_rdata : NIL_LINK;
            r_prev <= NIL_LINK;
        end else if (i_cmd.step) begin
            r_prev <= r_cur;
            r_cur  <= w_link_rdata;
        end
        if (i_cmd.load) begin
            r_found <= '0;
        end else if (i_cmd.take_value) begin
            r_found <= w_val_rdata;
        end
        if (i_cmd.rsp_load) begin
            r_out.status      <= i_cmd.status;
            r_out.found_value <= r_found;
            r_out.item_total  <= r_count;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc        <= CFG_W'(BUCKETS);
            r_mcnt      <= '0;
            r_scan_on   <= 1'b0;
            r_in_use    <= '0;
            r_head_vld  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bc <= i_cfg_wdata;
            end
            if (i_cmd.start) begin
                r_mcnt <= MCNT_W'(KEY_W);
            end else if (r_mcnt != '0) begin
                r_mcnt <= r_mcnt - MCNT_W'(1);
            end
            if (i_cmd.start) begin
                r_scan_on <= 1'b1;
            end else if (r_scan_on && (w_any || r_grp == GRP_W'(GROUPS - 1))) begin
                r_scan_on <= 1'b0;
            end
            if (i_cmd.wr_node) begin
                r_in_use[r_free_idx] <= 1'b1;
                r_count              <= r_count + ITEM_W'(1);
            end else if (i_cmd.unlink) begin
                r_in_use[r_cur[IDX_W-1:0]] <= 1'b0;
                if (r_count != '0) begin
                    r_count <= r_count - ITEM_W'(1);
                end
            end
            if (w_head_we) begin
                r_head_vld[r_rem] <= 1'b1;
            end
            if (i_cmd.rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.calc_done = (r_mcnt == '0) && !r_scan_on;
    assign o_sts.cur_nil   = (r_cur == NIL_LINK);
    assign o_sts.key_hit   = (w_key_rdata == r_req.key);
    assign o_sts.full      = (r_count == ITEM_W'(POOL_ENTRIES));
    assign o_sts.out_free  = !r_out_valid || i_rsp_ready;
    assign o_sts.mode      = t_mode'(r_req.mode);

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;
endmodule

// ----- rtl/chained_hash_map_top.sv -----
// Chained hash map top level: key to value map with separate chaining.
// i_req carries mode (add, delete, get), key and value; a request is taken
// when valid and ready are high at a rising edge. o_rsp returns one result
// per request: status, found value and the live entry count after it.
// Requests are handled one at a time; ready is high only while idle.
// A full-pool add or the unused mode goes from decode straight to the
// result. Other requests first run a bit-serial remainder unit that sets
// the bucket, then walk the chain, each node taking a registered read of
// the node store. An add that appends then writes the tail link in a
// state of its own.
// The result waits in an output register; a new request is accepted while
// it waits, and the next result holds until the receiver takes the first.
// i_cfg_we with i_cfg_wdata sets the bucket count (0 acts as 1, above 64
// acts as 64); write it only while no request is in flight.
// Synchronous active-low reset empties every bucket, frees the pool, zeroes
// the count and sets 64 buckets; no clearing pass is needed.
`timescale 1ns / 1ps
`include "chained_hash_map_top_macros.svh"
module chained_hash_map_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [chm_pkg::CFG_W-1:0] i_cfg_wdata,
    chm_req_if.sink                   i_req,
    chm_rsp_if.source                 o_rsp
);
    import chm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_req_ready;

    chm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    chm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req.payload),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp       (o_rsp.payload)
    );

    assign i_req.ready = w_req_ready;

    `CHM_ASSERT_NEXT(a_busy_after_accept, i_req.valid && i_req.ready, !i_req.ready)
    `CHM_ASSERT_SAME(a_total_bound, o_rsp.valid,
                     o_rsp.payload.item_total <= ITEM_W'(POOL_ENTRIES))
    `CHM_ASSERT_SAME(a_value_only_on_ok, o_rsp.valid && o_rsp.payload.status != ST_OK,
                     o_rsp.payload.found_value == '0)
    `CHM_ASSERT_SAME(a_one_write_source, w_cmd.wr_node || w_cmd.wr_tail,
                     !w_cmd.unlink && !w_cmd.take_value)
endmodule

// ----- tb/tb_chained_hash_map_top.sv -----
// testbench for the chained hash map: random add, delete and get requests checked against a predictor
`timescale 1ns / 1ps

class chm_scoreboard;
    localparam int NIL = chm_pkg::POOL_ENTRIES;

    int                             n_buckets;
    int                             head[chm_pkg::BUCKETS];
    logic [31:0]                    nkey[chm_pkg::POOL_ENTRIES];
    logic [31:0]                    nval[chm_pkg::POOL_ENTRIES];
    int                             nlink[chm_pkg::POOL_ENTRIES];
    bit                             used[chm_pkg::POOL_ENTRIES];
    int                             live;
    chm_pkg::t_rsp                  pending[$];
    int                             errors;

    function new();
        n_buckets = 64;
        for (int i = 0; i < chm_pkg::BUCKETS; i++) head[i] = NIL;
        for (int i = 0; i < NIL; i++) begin
            used[i] = 0;
            nlink[i] = NIL;
        end
        live = 0;
        errors = 0;
    endfunction

    function void set_buckets(logic [6:0] v);
        n_buckets = (v == 0) ? 1 : (v > chm_pkg::BUCKETS ? chm_pkg::BUCKETS : v);
    endfunction

    function int free_node();
        for (int i = 0; i < NIL; i++) if (!used[i]) return i;
        return NIL;
    endfunction

    function void note_request(chm_pkg::t_req r);
        chm_pkg::t_rsp e;
        int b, prev, cur, steps, n;
        bit hit;
        e.status = chm_pkg::ST_OK;
        e.found_value = 0;
        b = r.key % n_buckets;
        prev = NIL;
        cur = head[b];
        steps = 0;
        hit = 0;
        if (r.mode != chm_pkg::MODE_NOP) begin
            if (r.mode == chm_pkg::MODE_ADD && free_node() == NIL) begin
                e.status = chm_pkg::ST_FULL;
            end else begin
                while (cur < NIL && steps < NIL && !hit) begin
                    if (nkey[cur] == r.key) begin
                        hit = 1;
                    end else begin
                        prev = cur;
                        cur = nlink[cur];
                        steps++;
                    end
                end
                case (r.mode)
                    chm_pkg::MODE_ADD: begin
                        if (hit) begin
                            e.status = chm_pkg::ST_DUP;
                        end else begin
                            n = free_node();
                            nkey[n] = r.key;
                            nval[n] = r.value;
                            nlink[n] = NIL;
                            used[n] = 1;
                            if (prev < NIL) nlink[prev] = n;
                            else head[b] = n;
                            live++;
                        end
                    end
                    chm_pkg::MODE_DEL: begin
                        if (!hit) begin
                            e.status = chm_pkg::ST_NOTFOUND;
                        end else begin
                            if (prev < NIL) nlink[prev] = nlink[cur];
                            else head[b] = nlink[cur];
                            used[cur] = 0;
                            nlink[cur] = NIL;
                            if (live > 0) live--;
                        end
                    end
                    default: begin
                        if (hit) e.found_value = nval[cur];
                        else e.status = chm_pkg::ST_NOTFOUND;
                    end
                endcase
            end
        end
        e.item_total = live[8:0];
        pending.push_back(e);
    endfunction

    function void check_result(chm_pkg::t_rsp a);
        chm_pkg::t_rsp e;
        if (pending.size() == 0) begin
            $error("unexpected result %p", a);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (a.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, a.status);
            errors++;
        end
        if (a.found_value !== e.found_value) begin
            $error("found_value expected %h actual %h", e.found_value, a.found_value);
            errors++;
        end
        if (a.item_total !== e.item_total) begin
            $error("item_total expected %0d actual %0d", e.item_total, a.item_total);
            errors++;
        end
    endfunction
endclass

module tb_chained_hash_map_top;
    import chm_pkg::*;

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             i_cfg_we = 0;
    logic [CFG_W-1:0] i_cfg_wdata = 0;

    chm_req_if req_ch ();
    chm_rsp_if rsp_ch ();

    chained_hash_map_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    chm_scoreboard chain_model = new();
    logic [31:0]   key_pool[$];
    bit            sending_done = 0;

    initial req_ch.valid = 0;
    initial req_ch.payload = '0;
    initial rsp_ch.ready = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready) chain_model.check_result(rsp_ch.payload);
    end

    initial begin
        int g;
        forever begin
            @(posedge i_clk);
            if (g > 0) begin
                g--;
                rsp_ch.ready <= 0;
            end else begin
                rsp_ch.ready <= 1;
                if ($urandom_range(0, 9) < 3) g = gap_len();
            end
        end
    end

    task automatic send_request(t_mode m, logic [31:0] k, logic [31:0] v);
        t_req r;
        int   g;
        g = gap_len();
        if (g > 0) begin
            req_ch.valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        r.mode = m;
        r.key = k;
        r.value = v;
        req_ch.valid <= 1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        chain_model.note_request(r);
    endtask

    task automatic write_buckets(logic [6:0] v);
        req_ch.valid <= 0;
        while (chain_model.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        chain_model.set_buckets(v);
        i_cfg_we <= 0;
    endtask

    function automatic logic [31:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(0, 9) < 7)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return $urandom();
    endfunction

    task automatic random_phase(int count, int add_weight);
        int r;
        logic [31:0] k;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            k = pick_key();
            if (r < add_weight) begin
                key_pool.push_back(k);
                send_request(MODE_ADD, k, $urandom());
            end else if (r < add_weight + 20) send_request(MODE_DEL, k, $urandom());
            else if (r < 97) send_request(MODE_GET, k, $urandom());
            else send_request(MODE_NOP, k, $urandom());
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extremes, every mode, collisions
        send_request(MODE_GET, 32'h0, 32'h0);
        send_request(MODE_DEL, 32'hffff_ffff, 32'h0);
        send_request(MODE_ADD, 32'h0, 32'hffff_ffff);
        send_request(MODE_ADD, 32'hffff_ffff, 32'h0);
        send_request(MODE_ADD, 32'h0, 32'h1234_5678);
        send_request(MODE_ADD, 32'd64, 32'haaaa_5555);
        send_request(MODE_ADD, 32'd128, 32'h5555_aaaa);
        send_request(MODE_GET, 32'd128, 32'h0);
        send_request(MODE_DEL, 32'd64, 32'h0);
        send_request(MODE_GET, 32'd128, 32'h0);
        send_request(MODE_GET, 32'd64, 32'h0);
        send_request(MODE_NOP, 32'hffff_ffff, 32'hffff_ffff);
        send_request(MODE_GET, 32'hffff_ffff, 32'h0);
        send_request(MODE_DEL, 32'h0, 32'h0);
        write_buckets(7'd0);
        send_request(MODE_ADD, 32'd5, 32'd5);
        send_request(MODE_GET, 32'd128, 32'h0);
        write_buckets(7'd127);
        send_request(MODE_GET, 32'd5, 32'h0);
        send_request(MODE_GET, 32'd128, 32'h0);
        random_phase(250, 45);
        write_buckets(7'd1);
        random_phase(200, 40);
        write_buckets(7'd64);
        // fill the pool to reach the full case
        for (int i = 0; i < 280; i++) send_request(MODE_ADD, $urandom(), $urandom());
        random_phase(150, 30);
        write_buckets(7'd13);
        random_phase(200, 25);
        write_buckets(7'd1);
        for (int i = 0; i < 260; i++) send_request(MODE_DEL, pick_key(), 0);
        write_buckets(7'($urandom_range(2, 63)));
        random_phase(100, 45);
        req_ch.valid <= 0;
        sending_done = 1;
    end

    initial begin
        wait (sending_done);
        while (chain_model.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (chain_model.errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("simulation failed");
        $finish;
    end
endmodule
